// ----- rtl/core/unsorted_keyed_list_table_top_macros.svh -----
// Assertion helpers for the keyed list table.
`ifndef UNSORTED_KEYED_LIST_TABLE_TOP_MACROS_SVH
`define UNSORTED_KEYED_LIST_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UKL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ukl assertion failed");
`define UKL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ukl assertion failed");
`else
`define UKL_ASSERT_IMPL(label, ante, cons)
`define UKL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/ukl_pkg.sv -----
`timescale 1ns / 1ps

package ukl_pkg;

	localparam int DEPTH        = 64;
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int ENTRY_CNT_W  = 7;
	localparam int KEY_W        = 32;
	localparam int PAY_W        = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic                    cmp;
		logic                    del;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} cell_ctl_t;

endpackage

// ----- rtl/core/ukl_if.sv -----
`timescale 1ns / 1ps

interface ukl_req_if import ukl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	action_t                 action;
	logic signed [KEY_W-1:0] key;
	logic [PAY_W-1:0]        payload_in;

	modport source (output valid, action, key, payload_in, input ready);
	modport sink (input valid, action, key, payload_in, output ready);
endinterface

interface ukl_rsp_if import ukl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic [PAY_W-1:0]       payload_out;
	logic [ENTRY_CNT_W-1:0] entry_count;

	modport source (output valid, ok, payload_out, entry_count, input ready);
	modport sink (input valid, ok, payload_out, entry_count, output ready);
endinterface

// ----- rtl/core/unsorted_keyed_list_table_top.sv -----
`timescale 1ns / 1ps
// Keyed list table: up to DEPTH key/payload entries, packed in insertion order.
// req channel carries one request: action (insert, delete, search, clear),
// a signed key and a payload word. rsp channel returns one result per
// request: ok, the payload of the first match on a found search (else zero)
// and the entry count after the action.
// Each entry sits in a cell of a row; apart from the shared control and the
// payload OR, cell i talks only to cells i-1 and i+1. Each request passes
// through a compare state and an execute state. In compare, every cell
// registers whether its key matches. In execute, the first-match chain runs
// through the row, a delete shifts later cells up by one, and the result is
// loaded into the output register. The next request is accepted in execute.
// When rsp is stalled, a finished result waits in the output register; the
// following request is still accepted and compared, then holds in its
// execute cycle until the output register frees.
// Reset empties the table (count zero); entry contents are not cleared and
// are never read until written.
`include "unsorted_keyed_list_table_top_macros.svh"

module unsorted_keyed_list_table_top import ukl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ukl_req_if.sink   req,
	ukl_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	action_t                 act_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_in_q;
	logic                    ok_q;
	logic [PAY_W-1:0]        pay_out_q;
	logic [ENTRY_CNT_W-1:0]  cnt_out_q;

	logic                    exec_go;
	logic                    found;
	logic                    ok_nxt;
	logic [PAY_W-1:0]        pay_nxt;
	logic [CNT_W-1:0]        cnt_nxt;
	logic [PAY_W-1:0]        sel_or;
	cell_ctl_t               ctl;

	logic                    hit_w [DEPTH+1];
	logic signed [KEY_W-1:0] key_w [DEPTH+1];
	logic [PAY_W-1:0]        pay_w [DEPTH+1];
	logic [PAY_W-1:0]        sel_w [DEPTH];
	logic [DEPTH-1:0]        first_w;

	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE) || exec_go;

	assign ctl.cmp     = (state_q == ST_CMP);
	assign ctl.del     = exec_go && (act_q == ACT_DELETE);
	assign ctl.key     = key_q;
	assign ctl.payload = pay_in_q;

	assign hit_w[0]     = 1'b0;
	assign key_w[DEPTH] = '0;
	assign pay_w[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ukl_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (CNT_W'(i) < cnt_q),
			.ins_here (exec_go && (act_q == ACT_INSERT) && (cnt_q == CNT_W'(i))),
			.hit_in   (hit_w[i]),
			.hit_out  (hit_w[i+1]),
			.first    (first_w[i]),
			.nxt_key  (key_w[i+1]),
			.nxt_pay  (pay_w[i+1]),
			.key      (key_w[i]),
			.pay      (pay_w[i]),
			.sel_pay  (sel_w[i])
		);
	end

	assign found = hit_w[DEPTH];

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_or = sel_or | sel_w[i];
		end
	end

	always_comb begin
		ok_nxt  = 1'b0;
		pay_nxt = '0;
		cnt_nxt = cnt_q;
		case (act_q)
			ACT_INSERT: begin
				if (cnt_q < CNT_W'(DEPTH)) begin
					ok_nxt  = 1'b1;
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ACT_DELETE: begin
				if (found) begin
					ok_nxt  = 1'b1;
					cnt_nxt = cnt_q - 1'b1;
				end
			end
			ACT_SEARCH: begin
				if (found) begin
					ok_nxt  = 1'b1;
					pay_nxt = sel_or;
				end
			end
			default: begin
				ok_nxt  = 1'b1;
				cnt_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						cnt_q   <= cnt_nxt;
						state_q <= req.valid ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q    <= req.action;
			key_q    <= req.key;
			pay_in_q <= req.payload_in;
		end
		if (exec_go) begin
			ok_q      <= ok_nxt;
			pay_out_q <= pay_nxt;
			cnt_out_q <= ENTRY_CNT_W'(cnt_nxt);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.payload_out = pay_out_q;
	assign rsp.entry_count = cnt_out_q;

	`UKL_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`UKL_ASSERT_IMPL(a_first_onehot, state_q == ST_EXEC, $onehot0(first_w))
	`UKL_ASSERT_NEXT(a_exec_result, exec_go, rsp.valid)
	`UKL_ASSERT_NEXT(a_insert_grow, exec_go && act_q == ACT_INSERT && cnt_q < CNT_W'(DEPTH),
		cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ----- rtl/core/ukl_cell.sv -----
`timescale 1ns / 1ps

module ukl_cell import ukl_pkg::*; (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic                    occupied,
	input  logic                    ins_here,
	input  logic                    hit_in,
	output logic                    hit_out,
	output logic                    first,
	input  logic signed [KEY_W-1:0] nxt_key,
	input  logic [PAY_W-1:0]        nxt_pay,
	output logic signed [KEY_W-1:0] key,
	output logic [PAY_W-1:0]        pay,
	output logic [PAY_W-1:0]        sel_pay
);

	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;
	logic                    match_q;

	assign hit_out = hit_in | match_q;
	assign first   = match_q & ~hit_in;
	assign sel_pay = first ? pay_q : '0;
	assign key     = key_q;
	assign pay     = pay_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			match_q <= occupied && (key_q == ctl.key);
		end
		// at or past the deleted entry: take the neighbor's contents
		if (ctl.del && hit_out) begin
			key_q <= nxt_key;
			pay_q <= nxt_pay;
		end else if (ins_here) begin
			key_q <= ctl.key;
			pay_q <= ctl.payload;
		end
	end

endmodule
